// ----- src/mca_pkg.sv -----
// ---------------------------------------------------------------------------
// mca_pkg: shared types and constants
// Cell kinds, command codes, register indexes, sequencer states and the
// oil-familiar threshold table of the membrane cellular automaton.
// ---------------------------------------------------------------------------
package mca_pkg;

  // Cell kinds
  localparam logic [2:0] KIND_WATER    = 3'd0;
  localparam logic [2:0] KIND_OIL      = 3'd1;
  localparam logic [2:0] KIND_MEMBRANE = 3'd2;
  localparam logic [2:0] KIND_OFAMIL   = 3'd3;
  localparam logic [2:0] KIND_OTHER    = 3'd4;

  // Commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_GEN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RANGE  = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDWAIT,
    ST_COPY,
    ST_COPYEND,
    ST_WIN,
    ST_WDRAIN,
    ST_DECIDE,
    ST_DONE
  } mca_state_t;

  // Write enables toward the two grid memories
  typedef struct packed {
    logic pres_we;
    logic prior_we;
  } mca_wen_t;

  // floor(3 * (2r+1)^2 / 5) for each window radius
  function automatic logic [7:0] ofam_thr(input logic [2:0] r);
    logic [7:0] t;
    begin
      case (r)
        3'd1:    t = 8'd5;
        3'd2:    t = 8'd15;
        3'd3:    t = 8'd29;
        3'd4:    t = 8'd48;
        3'd5:    t = 8'd72;
        3'd6:    t = 8'd101;
        3'd7:    t = 8'd135;
        default: t = 8'd0;
      endcase
      return t;
    end
  endfunction

endpackage

// ----- src/mca_grid.sv -----
// ---------------------------------------------------------------------------
// mca_grid: present and prior grid memories
// Two single-write, single-read memories of 3-bit cells with registered
// read data.
// ---------------------------------------------------------------------------
module mca_grid import mca_pkg::*; #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  mca_wen_t      wen,
  input  logic [AW-1:0] pres_waddr,
  input  logic [2:0]    pres_wdata,
  input  logic [AW-1:0] pres_raddr,
  output logic [2:0]    pres_rdata,
  input  logic [AW-1:0] prior_waddr,
  input  logic [2:0]    prior_wdata,
  input  logic [AW-1:0] prior_raddr,
  output logic [2:0]    prior_rdata
);

  logic [2:0] pres_mem  [2**AW];
  logic [2:0] prior_mem [2**AW];
  logic [2:0] pres_rdata_r;
  logic [2:0] prior_rdata_r;

  // Present grid
  always_ff @(posedge clk) begin
    if (wen.pres_we) begin
      pres_mem[pres_waddr] <= pres_wdata;
    end
    pres_rdata_r <= pres_mem[pres_raddr];
  end

  // Prior grid
  always_ff @(posedge clk) begin
    if (wen.prior_we) begin
      prior_mem[prior_waddr] <= prior_wdata;
    end
    prior_rdata_r <= prior_mem[prior_raddr];
  end

  assign pres_rdata  = pres_rdata_r;
  assign prior_rdata = prior_rdata_r;

endmodule

// ----- src/mca_ctrl.sv -----
// ---------------------------------------------------------------------------
// mca_ctrl: command sequencer and window counting unit
// Clears the grids after reset, serves cell writes and reads, and runs a
// generation as a copy pass followed by a cell walk that reads one window
// cell per cycle into a shared set of kind counters.
// ---------------------------------------------------------------------------
module mca_ctrl import mca_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_RANGE  = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     eff_h,
  input  logic [$clog2(MAX_RANGE+1)-1:0]      eff_r,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_command,
  input  logic [5:0]                          in_cell_x,
  input  logic [5:0]                          in_cell_y,
  input  logic [2:0]                          in_write_kind,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_read_kind,
  output mca_wen_t                            wen,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] pres_waddr,
  output logic [2:0]                          pres_wdata,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] pres_raddr,
  input  logic [2:0]                          pres_rdata,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] prior_waddr,
  output logic [2:0]                          prior_wdata,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] prior_raddr,
  input  logic [2:0]                          prior_rdata
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int RW = $clog2(MAX_RANGE+1);
  localparam int AW = XW + YW;
  localparam int SW = $clog2(2*MAX_RANGE+2);
  localparam int NW = $clog2((2*MAX_RANGE+1)*(2*MAX_RANGE+1)+1);
  localparam int TW = NW + 1;

  mca_state_t state_r, state_nxt;

  logic [AW-1:0] addr_r;
  logic          cp_v_r;
  logic [AW-1:0] cp_a_r;
  logic [XW-1:0] cx_r, wx_r;
  logic [YW-1:0] cy_r, wy_r;
  logic [SW-1:0] i_r, j_r;
  logic          tag_v_r, tag_c_r;
  logic [NW-1:0] cnt_w_r, cnt_o_r, cnt_m_r, cnt_f_r;
  logic [2:0]    prev_r;
  logic [2:0]    res_r;
  logic          out_valid_r;
  logic [2:0]    out_kind_r;

  // Start column of a window: c - r wrapped into the grid width.
  function automatic logic [XW-1:0] start_x(input logic [XW-1:0] c);
    logic [WW:0] cw, rw;
    begin
      cw = (WW+1)'(c);
      rw = (WW+1)'(eff_r);
      if (cw >= rw) start_x = XW'(cw - rw);
      else          start_x = XW'(cw + (WW+1)'(eff_w) - rw);
    end
  endfunction

  function automatic logic [YW-1:0] start_y(input logic [YW-1:0] c);
    logic [HW:0] cw, rw;
    begin
      cw = (HW+1)'(c);
      rw = (HW+1)'(eff_r);
      if (cw >= rw) start_y = YW'(cw - rw);
      else          start_y = YW'(cw + (HW+1)'(eff_h) - rw);
    end
  endfunction

  // Handshake and command decode
  logic          accept;
  logic          cell_in_grid;
  logic [AW-1:0] in_addr;
  logic [2:0]    in_kind;
  logic          out_load;

  assign in_stall     = (state_r != ST_IDLE);
  assign accept       = in_valid && !in_stall;
  assign cell_in_grid = (16'(in_cell_x) < 16'(eff_w)) && (16'(in_cell_y) < 16'(eff_h));
  assign in_addr      = {YW'(in_cell_y), XW'(in_cell_x)};
  assign in_kind      = (in_write_kind > KIND_OTHER) ? KIND_OTHER : in_write_kind;
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Grid geometry and thresholds
  logic [XW-1:0] last_x;
  logic [YW-1:0] last_y;
  logic [SW-1:0] last_i;
  logic [SW-1:0] r_s;
  logic          win_end_row, win_end;
  logic          cell_end_row, cell_end;

  assign last_x       = XW'(eff_w - 1'b1);
  assign last_y       = YW'(eff_h - 1'b1);
  assign r_s          = SW'(eff_r);
  assign last_i       = SW'({r_s, 1'b0});
  assign win_end_row  = (i_r == last_i);
  assign win_end      = win_end_row && (j_r == last_i);
  assign cell_end_row = (cx_r == last_x);
  assign cell_end     = cell_end_row && (cy_r == last_y);

  logic [TW-1:0] r_t, side_t, thr_change, thr_mmax, thr_two_r, thr_ofam;
  assign r_t        = TW'(eff_r);
  assign side_t     = TW'({r_t, 1'b0}) + TW'(1);
  assign thr_two_r  = TW'({r_t, 1'b0});
  assign thr_change = TW'(r_t * side_t) + thr_two_r;
  assign thr_mmax   = thr_two_r + r_t + TW'(1);
  assign thr_ofam   = TW'(ofam_thr(3'(eff_r)));

  // Rule evaluation on the finished window counts
  logic [TW-1:0] oily, diff;
  logic [2:0]    new_kind;

  always_comb begin
    oily = TW'(cnt_o_r) + TW'(cnt_f_r);
    diff = (TW'(cnt_w_r) > oily) ? TW'(cnt_w_r) - oily : oily - TW'(cnt_w_r);
    new_kind = prev_r;
    if (cnt_m_r != '0 && TW'(cnt_m_r) < thr_mmax && diff <= thr_two_r) begin
      new_kind = KIND_MEMBRANE;
    end else if (cnt_f_r != '0 && TW'(cnt_f_r) < thr_two_r
                 && TW'(cnt_o_r) > thr_ofam) begin
      new_kind = KIND_OFAMIL;
    end else begin
      case (prev_r)
        KIND_WATER:    if (oily >= thr_change) new_kind = KIND_OIL;
        KIND_OIL:      if (TW'(cnt_w_r) >= thr_change) new_kind = KIND_WATER;
        KIND_MEMBRANE: new_kind = (TW'(cnt_w_r) > oily) ? KIND_WATER : KIND_OIL;
        KIND_OFAMIL:   new_kind = KIND_OIL;
        default:       new_kind = prev_r;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (addr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_GEN) state_nxt = ST_COPY;
          else if (in_command == CMD_READ && cell_in_grid) state_nxt = ST_RDWAIT;
          else state_nxt = ST_DONE;
        end
      end
      ST_RDWAIT:  state_nxt = ST_DONE;
      ST_COPY:    if (addr_r == '1) state_nxt = ST_COPYEND;
      ST_COPYEND: state_nxt = ST_WIN;
      ST_WIN:     if (win_end) state_nxt = ST_WDRAIN;
      ST_WDRAIN:  state_nxt = ST_DECIDE;
      ST_DECIDE:  state_nxt = cell_end ? ST_DONE : ST_WIN;
      ST_DONE:    if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  // Memory port control
  always_comb begin
    wen.pres_we  = 1'b0;
    wen.prior_we = cp_v_r;
    pres_waddr   = in_addr;
    pres_wdata   = in_kind;
    pres_raddr   = in_addr;
    prior_waddr  = cp_a_r;
    prior_wdata  = pres_rdata;
    prior_raddr  = {wy_r, wx_r};
    unique case (state_r)
      ST_CLEAR: begin
        wen.pres_we  = 1'b1;
        wen.prior_we = 1'b1;
        pres_waddr   = addr_r;
        pres_wdata   = KIND_WATER;
        prior_waddr  = addr_r;
        prior_wdata  = KIND_WATER;
      end
      ST_IDLE:   wen.pres_we = accept && (in_command == CMD_WRITE) && cell_in_grid;
      ST_COPY:   pres_raddr = addr_r;
      ST_DECIDE: begin
        wen.pres_we = 1'b1;
        pres_waddr  = {cy_r, cx_r};
        pres_wdata  = new_kind;
      end
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      cp_v_r      <= 1'b0;
      tag_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cp_v_r  <= (state_r == ST_COPY);
      tag_v_r <= (state_r == ST_WIN);
      if (state_r == ST_CLEAR || state_r == ST_COPY) addr_r <= addr_r + 1'b1;
      else addr_r <= '0;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers: cell walk, window walk, counters and result
  always_ff @(posedge clk) begin
    cp_a_r  <= addr_r;
    tag_c_r <= (i_r == r_s) && (j_r == r_s);
    if (out_load) out_kind_r <= res_r;

    // Accumulate the window cell that the memory returned.
    if (tag_v_r) begin
      case (prior_rdata)
        KIND_WATER:    cnt_w_r <= cnt_w_r + 1'b1;
        KIND_OIL:      cnt_o_r <= cnt_o_r + 1'b1;
        KIND_MEMBRANE: cnt_m_r <= cnt_m_r + 1'b1;
        KIND_OFAMIL:   cnt_f_r <= cnt_f_r + 1'b1;
        default: ;
      endcase
      if (tag_c_r) prev_r <= prior_rdata;
    end

    unique case (state_r)
      ST_IDLE: res_r <= KIND_WATER;
      ST_RDWAIT: res_r <= pres_rdata;
      ST_COPYEND: begin
        cx_r    <= '0;
        cy_r    <= '0;
        wx_r    <= start_x('0);
        wy_r    <= start_y('0);
        i_r     <= '0;
        j_r     <= '0;
        cnt_w_r <= '0;
        cnt_o_r <= '0;
        cnt_m_r <= '0;
        cnt_f_r <= '0;
      end
      ST_WIN: begin
        if (win_end_row) begin
          i_r  <= '0;
          j_r  <= j_r + 1'b1;
          wx_r <= start_x(cx_r);
          wy_r <= (wy_r == last_y) ? '0 : wy_r + 1'b1;
        end else begin
          i_r  <= i_r + 1'b1;
          wx_r <= (wx_r == last_x) ? '0 : wx_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        i_r     <= '0;
        j_r     <= '0;
        cnt_w_r <= '0;
        cnt_o_r <= '0;
        cnt_m_r <= '0;
        cnt_f_r <= '0;
        if (cell_end_row) begin
          cx_r <= '0;
          wx_r <= start_x('0);
          cy_r <= cy_r + 1'b1;
          wy_r <= start_y(cy_r + 1'b1);
        end else begin
          cx_r <= cx_r + 1'b1;
          wx_r <= start_x(cx_r + 1'b1);
          wy_r <= start_y(cy_r);
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_read_kind = out_kind_r;

endmodule

// ----- src/membrane_cellular_automaton_top.sv -----
// ---------------------------------------------------------------------------
// membrane_cellular_automaton_top: membrane cellular automaton
// Configuration registers with range clamping, the command sequencer and
// the two grid memories.
//
//   Port group | Direction | Handshake        | Beat
//   cfg_       | in        | cfg_we           | register index and value
//   in_        | in        | in_valid/in_stall| command, cell_x, cell_y, kind
//   out_       | out       | out_valid/out_stall | read_kind
//
// After reset a clearing pass writes water to every cell, 2**(clog2(MAX_WIDTH)
// + clog2(MAX_HEIGHT)) cells (4096 by default); no beat is taken meanwhile.
// A write or unused command goes straight to the result; a read of a cell
// inside the grid first waits for the registered read data. A generation
// runs a copy pass over the whole memory, then walks each cell's window, one
// window cell read per cycle from the prior grid port. The result waits in an
// output register under out_stall while the next command is taken.
// ---------------------------------------------------------------------------
module membrane_cellular_automaton_top import mca_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_RANGE  = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [5:0] in_cell_x,
  input  logic [5:0] in_cell_y,
  input  logic [2:0] in_write_kind,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_read_kind
);

  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int RW = $clog2(MAX_RANGE+1);
  localparam int AW = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);

  logic [6:0] grid_width_r, grid_height_r;
  logic [1:0] range_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 7'd64;
      grid_height_r <= 7'd64;
      range_r       <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  grid_width_r  <= cfg_data;
        CFG_HEIGHT: grid_height_r <= cfg_data;
        CFG_RANGE:  range_r       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Clamp the sizes into the supported range.
  logic [15:0] w16, h16, r16;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [RW-1:0] eff_r;

  always_comb begin
    w16 = 16'(grid_width_r);
    h16 = 16'(grid_height_r);
    r16 = 16'(range_r);
    if (w16 < 16'd4) w16 = 16'd4;
    else if (w16 > 16'(MAX_WIDTH)) w16 = 16'(MAX_WIDTH);
    if (h16 < 16'd4) h16 = 16'd4;
    else if (h16 > 16'(MAX_HEIGHT)) h16 = 16'(MAX_HEIGHT);
    if (r16 < 16'd1) r16 = 16'd1;
    else if (r16 > 16'(MAX_RANGE)) r16 = 16'(MAX_RANGE);
    eff_w = WW'(w16);
    eff_h = HW'(h16);
    eff_r = RW'(r16);
  end

  mca_wen_t      wen;
  logic [AW-1:0] pres_waddr, pres_raddr, prior_waddr, prior_raddr;
  logic [2:0]    pres_wdata, pres_rdata, prior_wdata, prior_rdata;

  mca_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RANGE  (MAX_RANGE)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .eff_w         (eff_w),
    .eff_h         (eff_h),
    .eff_r         (eff_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .in_write_kind (in_write_kind),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_kind (out_read_kind),
    .wen           (wen),
    .pres_waddr    (pres_waddr),
    .pres_wdata    (pres_wdata),
    .pres_raddr    (pres_raddr),
    .pres_rdata    (pres_rdata),
    .prior_waddr   (prior_waddr),
    .prior_wdata   (prior_wdata),
    .prior_raddr   (prior_raddr),
    .prior_rdata   (prior_rdata)
  );

  mca_grid #(
    .AW (AW)
  ) u_grid (
    .clk         (clk),
    .wen         (wen),
    .pres_waddr  (pres_waddr),
    .pres_wdata  (pres_wdata),
    .pres_raddr  (pres_raddr),
    .pres_rdata  (pres_rdata),
    .prior_waddr (prior_waddr),
    .prior_wdata (prior_wdata),
    .prior_raddr (prior_raddr),
    .prior_rdata (prior_rdata)
  );

endmodule
